// ----- sv/bsre_pkg.sv -----
// bsre_pkg: shared constants, command/status structs and bit-scan helpers
// for the bitmap set-run extractor. No dependencies.
package bsre_pkg;

  localparam int WORD_BITS = 64;
  localparam int IDX_W     = $clog2(WORD_BITS);
  localparam int CUR_W     = $clog2(WORD_BITS + 1);
  localparam int POS_W     = 33;
  localparam int DATA_W    = 32;

  localparam logic [POS_W-1:0] POS_LIMIT = {1'b1, {(POS_W-1){1'b0}}};

  typedef logic [WORD_BITS-1:0] word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // take a new map word
    logic open_run;  // first set bit found, start a run
    logic emit;      // close the open run into the pending slot
    logic finish;    // word done, flush pending with the last mark
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic found;       // a transition exists at or above the cursor
    logic run_open;
    logic close_end;   // open run ends at the first ignored index
    logic pend_valid;
    logic out_free;    // output register can load this cycle
  } dp_status_t;

  // index of the lowest set bit (0 when none)
  function automatic logic [IDX_W-1:0] first_set(input word_t x);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (x[i]) begin
        idx = IDX_W'(i);
      end
    end
    return idx;
  endfunction

  // bits below n are set; n may equal WORD_BITS
  function automatic word_t low_mask(input logic [CUR_W-1:0] n);
    word_t m;
    for (int i = 0; i < WORD_BITS; i++) begin
      m[i] = (CUR_W'(i) < n);
    end
    return m;
  endfunction

endpackage

// ----- sv/bitmap_set_run_extractor_unit.sv -----
// Bitmap set-run extractor: after a word is accepted, a run that starts in it
// takes a step to find its first set bit and one to find its end, one carried
// in or left open only one of them, and a last step ends the word; closes and
// the last step wait while output is blocked. A closed run waits in the pending
// slot until the next close or the word's last step, then moves to the output
// register. Sync active-high reset clears state; total_bits goes all ones.
module bitmap_set_run_extractor_unit
  import bsre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // configuration: total_bits, write only while idle
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [DATA_W-1:0] cfg_data,
  // map word input
  input  logic              in_valid,
  output logic              in_stall,
  input  word_t             map_word,
  // run results
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] run_start,
  output logic [DATA_W-1:0] run_length,
  output logic              last_of_word,
  output logic              map_done
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // register always writable; the user must use the port only between words (not enforced)
  assign cfg_ready = 1'b1;

  // Controller walks each word: open on a set bit, close on a clear bit or
  // at the end of the map, then flush the held result with the last mark.
  // The bit scanner finds one transition per cycle unless a close or the
  // word's end is held by a stalled output register with a pending run.
  bsre_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath: a closed run sits in a pending slot until the next one (or
  // the end of the word) tells whether it is the last of its word.
  bsre_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_data     (cfg_data),
    .map_word     (map_word),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .run_start    (run_start),
    .run_length   (run_length),
    .last_of_word (last_of_word),
    .map_done     (map_done)
  );

endmodule

// ----- sv/bsre_ctrl.sv -----
// bsre_ctrl: controller state machine for the run extractor.
// Depends on bsre_pkg (command and status structs).
module bsre_ctrl
  import bsre_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic {
    IDLE,
    SCAN
  } state_t;

  state_t state;
  state_t state_next;

  logic push_ok;

  assign in_stall = (state != IDLE);
  assign push_ok  = !status.pend_valid || status.out_free;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = SCAN;
        end
      end
      SCAN: begin
        priority if (status.found && !status.run_open) begin
          cmd.open_run = 1'b1;
        end else if (status.found || status.close_end) begin
          cmd.emit = push_ok;
        end else if (push_ok) begin
          cmd.finish = 1'b1;
          state_next = IDLE;
        end
      end
      default: state_next = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/bsre_datapath.sv -----
// bsre_datapath: word register, bit scanner, run state, pending slot and
// output register. Depends on bsre_pkg.
module bsre_datapath
  import bsre_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [DATA_W-1:0] cfg_data,
  input  word_t             map_word,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [DATA_W-1:0] run_start,
  output logic [DATA_W-1:0] run_length,
  output logic              last_of_word,
  output logic              map_done
);

  logic [DATA_W-1:0] total_bits;
  logic [POS_W-1:0]  bit_position;
  logic              run_open;
  logic [DATA_W-1:0] open_run_start;

  word_t             word;
  logic [CUR_W-1:0]  valid_cnt;
  logic [CUR_W-1:0]  cursor;
  logic [POS_W-1:0]  base;

  logic              pend_valid;
  logic [DATA_W-1:0] pend_start;
  logic [DATA_W-1:0] pend_len;
  logic              pend_done;

  // load-time values
  logic [POS_W-1:0]  total_ext;
  logic [POS_W-1:0]  remain;
  logic [CUR_W-1:0]  valid_cnt_load;
  logic [POS_W-1:0]  pos_step;

  // scan
  word_t             vmask;
  word_t             search;
  logic              found;
  logic [IDX_W-1:0]  hit;
  logic [POS_W-1:0]  end_pos;
  logic [POS_W-1:0]  len_raw;
  logic [DATA_W-1:0] len_sat;
  logic              out_load;

  assign total_ext = {1'b0, total_bits};
  assign remain    = total_ext - bit_position;
  assign pos_step  = bit_position + POS_W'(WORD_BITS);

  always_comb begin
    if (total_ext <= bit_position) begin
      valid_cnt_load = '0;
    end else if (remain >= POS_W'(WORD_BITS)) begin
      valid_cnt_load = CUR_W'(WORD_BITS);
    end else begin
      valid_cnt_load = remain[CUR_W-1:0];
    end
  end

  assign vmask   = low_mask(valid_cnt);
  assign search  = (run_open ? (~word & vmask) : word) & ~low_mask(cursor);
  assign found   = |search;
  assign hit     = first_set(search);
  assign end_pos = found ? (base + POS_W'(hit)) : (base + POS_W'(valid_cnt));
  assign len_raw = end_pos - {1'b0, open_run_start};
  assign len_sat = len_raw[POS_W-1] ? '1 : len_raw[DATA_W-1:0];

  assign out_load = (cmd.emit || cmd.finish) && pend_valid;

  always_comb begin
    status.found      = found;
    status.run_open   = run_open;
    status.close_end  = !found && run_open && (valid_cnt != CUR_W'(WORD_BITS));
    status.pend_valid = pend_valid;
    status.out_free   = !out_valid || !out_stall;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      total_bits     <= '1;
      bit_position   <= '0;
      run_open       <= 1'b0;
      open_run_start <= '0;
      pend_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        total_bits <= cfg_data;
      end
      if (cmd.load) begin
        bit_position <= (pos_step > POS_LIMIT) ? POS_LIMIT : pos_step;
      end
      if (cmd.open_run) begin
        run_open       <= 1'b1;
        open_run_start <= base[DATA_W-1:0] + DATA_W'(hit);
      end else if (cmd.emit) begin
        run_open <= 1'b0;
      end
      if (cmd.emit) begin
        pend_valid <= 1'b1;
      end else if (cmd.finish) begin
        pend_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      word      <= map_word & low_mask(valid_cnt_load);
      valid_cnt <= valid_cnt_load;
      base      <= bit_position;
      cursor    <= '0;
    end else if (cmd.open_run || (cmd.emit && found)) begin
      cursor <= CUR_W'(hit) + CUR_W'(1);
    end else if (cmd.emit) begin
      // closed at the map end: nothing left to scan in this word
      cursor <= valid_cnt;
    end
    if (cmd.emit) begin
      pend_start <= open_run_start;
      pend_len   <= len_sat;
      pend_done  <= !found;
    end
    if (out_load) begin
      run_start    <= pend_start;
      run_length   <= pend_len;
      map_done     <= pend_done;
      last_of_word <= cmd.finish;
    end
  end

endmodule
